// ===== rtl/core/sbmq_pkg.sv =====
// Shared constants and status codes for the shared-buffer multi-queue.
package sbmq_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int QUEUES_DEF     = 4;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W = 32;
  localparam int SEL_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [VALUE_W-1:0] UNDERFLOW_VALUE = '1;

endpackage

// ===== rtl/core/sbmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/shared_buffer_multi_queue.sv =====
// Several FIFO queues sharing one entry store through a linked free list.
// Enqueue and error results are registered from the execute state (S_EXEC); a successful
// dequeue reads the head there, then link/data in S_DEQ, and its result is registered from S_DEQ.
// A new item is taken only in idle, once the last one has finished, as the dependent reads
// of the head/tail and link RAMs come first; a waiting result only stalls the finish.
// Reset: synchronous, clears queue-written bits, free head and high-water count; the link
// store is never swept, untouched entries follow the high-water count.
module shared_buffer_multi_queue
  import sbmq_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int QUEUES     = QUEUES_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // value_in
  input  logic [2:0]         in_tuser,   // op, queue_sel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // value_out
  output logic [STAT_W-1:0]  out_tuser   // status
);

  localparam int PW  = $clog2(ENTRIES + 1);
  localparam int EAW = $clog2(ENTRIES);
  localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DEQ  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic                  op_r;
  logic [SEL_W-1:0]      q_r;
  logic [VALUE_W-1:0]    val_r;
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [PW-1:0]         hw_r, hw_nxt;
  logic [QUEUES-1:0]     qwr_r, qwr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_value_r, out_value_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;

  logic                  in_xfer;
  logic                  done_ok;
  logic                  q_ok;
  logic [QW-1:0]         q_idx;
  logic [PW-1:0]         head_q;
  logic                  head_ok;
  logic                  free_ok;

  // RAM ports
  logic [QW-1:0]         qt_raddr;
  logic                  head_we, tail_we, link_we, data_we;
  logic [PW-1:0]         head_wdata, link_wdata;
  logic [EAW-1:0]        link_waddr, link_raddr;
  logic [PW-1:0]         head_rd, tail_rd, link_rd;
  logic [DATA_WIDTH-1:0] data_rd;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign done_ok   = !out_valid_r || out_tready;

  assign q_ok    = ({6'd0, q_r} < 8'(QUEUES));
  assign q_idx   = QW'(q_r);
  assign head_q  = (q_ok && qwr_r[q_idx]) ? head_rd : NIL;
  assign head_ok = (head_q < NIL);
  assign free_ok = (free_head_r < NIL);

  assign qt_raddr = (state_r == S_IDLE) ? QW'(in_tuser[2:1]) : q_idx;

  always_comb begin
    link_raddr = free_head_r[EAW-1:0];
    if (state_r == S_DEQ || (state_r == S_EXEC && op_r == OP_DEQ)) begin
      link_raddr = head_q[EAW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    hw_nxt         = hw_r;
    qwr_nxt        = qwr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    head_we        = 1'b0;
    tail_we        = 1'b0;
    link_we        = 1'b0;
    data_we        = 1'b0;
    head_wdata     = free_head_r;
    link_waddr     = tail_rd[EAW-1:0];
    link_wdata     = free_head_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_ENQ) begin
          if (done_ok) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            if (!q_ok || !free_ok) begin
              out_status_nxt = STAT_OVERFLOW;
            end else begin
              out_status_nxt = STAT_OK;
              data_we        = 1'b1;
              tail_we        = 1'b1;
              if (head_ok) begin
                link_we = 1'b1;  // append after current tail
              end else begin
                head_we        = 1'b1;
                qwr_nxt[q_idx] = 1'b1;
              end
              // entries at the high-water mark were never touched: link is index+1
              if (free_head_r == hw_r) begin
                free_head_nxt = hw_r + 1'b1;
                hw_nxt        = hw_r + 1'b1;
              end else begin
                free_head_nxt = link_rd;
              end
            end
          end
        end else if (head_ok) begin
          state_nxt = S_DEQ;
        end else if (done_ok) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = UNDERFLOW_VALUE;
          out_status_nxt = STAT_UNDERFLOW;
        end
      end
      S_DEQ: begin
        if (done_ok) begin
          state_nxt      = S_IDLE;
          // a tail's link is not cleared, so a one-entry queue is found by head equal to tail and empties here
          head_we        = 1'b1;
          head_wdata     = (head_q == tail_rd) ? NIL : link_rd;
          link_we        = 1'b1;
          link_waddr     = head_q[EAW-1:0];
          link_wdata     = free_head_r;
          free_head_nxt  = head_q;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = VALUE_W'($signed(data_rd));
          out_status_nxt = STAT_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      hw_r        <= '0;
      qwr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      qwr_r       <= qwr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_tuser[0];
      q_r   <= in_tuser[2:1];
      val_r <= in_tdata;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  sbmq_ram #(.WIDTH(PW), .DEPTH(QUEUES)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (q_idx),
    .wdata (head_wdata),
    .raddr (qt_raddr),
    .rdata (head_rd)
  );

  sbmq_ram #(.WIDTH(PW), .DEPTH(QUEUES)) u_tail_ram (
    .clk   (clk),
    .we    (tail_we),
    .waddr (q_idx),
    .wdata (free_head_r),
    .raddr (qt_raddr),
    .rdata (tail_rd)
  );

  sbmq_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rd)
  );

  sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (free_head_r[EAW-1:0]),
    .wdata (DATA_WIDTH'($unsigned(val_r))),
    .raddr (head_q[EAW-1:0]),
    .rdata (data_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  // free list head never runs ahead of the high-water mark
  a_free_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r <= hw_r) && (hw_r <= NIL))
    else $error("free head beyond high-water mark");

  // a result only appears when the sequencer finishes an item
  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_DEQ))
    else $error("result without a finished item");

  // every accepted item moves the sequencer out of idle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

endmodule

// ===== test/testbench.sv =====
// Testbench for the shared-buffer multi-queue: stream traffic, in-bench queue model, checks.
module testbench
  import sbmq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = ENTRIES_DEF;
  localparam int NUM_QUEUES  = QUEUES_DEF;
  localparam logic [4:0] NULL_LINK = 5'(NUM_ENTRIES);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [STAT_W-1:0]  status;
  } queue_reply_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata;   // value_in
  logic [2:0]         in_tuser;   // op, queue_sel
  logic               out_tvalid;
  logic               out_tready;
  logic [VALUE_W-1:0] out_tdata;  // value_out
  logic [STAT_W-1:0]  out_tuser;  // status

  // Model of the linked store
  logic [VALUE_W-1:0] slot_value [NUM_ENTRIES];
  logic [4:0]         slot_next  [NUM_ENTRIES];
  logic [4:0]         q_head     [NUM_QUEUES];
  logic [4:0]         q_tail     [NUM_QUEUES];
  logic [4:0]         free_ptr;

  queue_reply_t pending_replies[$];
  bit           steady_flow;
  int           error_count;
  int           n_ok, n_overflow, n_underflow, n_enq_sent, n_deq_sent;

  shared_buffer_multi_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void clear_queue_model();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = (i + 1 < NUM_ENTRIES) ? 5'(i + 1) : NULL_LINK;
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = NULL_LINK;
      q_tail[i] = NULL_LINK;
    end
    free_ptr = '0;
  endfunction

  function automatic queue_reply_t predict_queue_op(logic op, logic [1:0] qsel,
                                                    logic [VALUE_W-1:0] val);
    queue_reply_t r;
    logic [4:0]   idx;
    if (op == OP_ENQ) begin
      r.value = '0;
      if (int'(qsel) >= NUM_QUEUES || free_ptr >= NUM_ENTRIES) begin
        r.status = STAT_OVERFLOW;
      end else begin
        idx      = free_ptr;
        free_ptr = slot_next[idx];
        // an emptied queue keeps a stale tail; a null head means start over
        if (q_head[qsel] >= NUM_ENTRIES) begin
          q_head[qsel] = idx;
        end else if (q_tail[qsel] < NUM_ENTRIES) begin
          slot_next[q_tail[qsel]] = idx;
        end
        slot_next[idx]  = NULL_LINK;
        q_tail[qsel]    = idx;
        slot_value[idx] = val;
        r.status        = STAT_OK;
      end
    end else begin
      if (int'(qsel) >= NUM_QUEUES || q_head[qsel] >= NUM_ENTRIES) begin
        r.value  = UNDERFLOW_VALUE;
        r.status = STAT_UNDERFLOW;
      end else begin
        idx            = q_head[qsel];
        q_head[qsel]   = slot_next[idx];
        slot_next[idx] = free_ptr;
        free_ptr       = idx;
        r.value        = slot_value[idx];
        r.status       = STAT_OK;
      end
    end
    return r;
  endfunction

  // Called at a falling edge, returns at a falling edge.
  task automatic send_item(logic op, logic [1:0] qsel, logic [VALUE_W-1:0] val);
    while (!steady_flow && $urandom_range(99) < 34) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = {qsel, op};
    in_tdata  = val;
    do @(posedge clk); while (!in_tready);
    pending_replies.push_back(predict_queue_op(op, qsel, val));
    if (op == OP_ENQ) n_enq_sent++;
    else n_deq_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_replies_drained();
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    queue_reply_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result: value_out %h status %0d", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_tdata !== exp_r.value) begin
          $error("value_out mismatch: expected %h, got %h", exp_r.value, out_tdata);
          error_count++;
        end
        if (out_tuser !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, out_tuser);
          error_count++;
        end
        case (exp_r.status)
          STAT_OK:       n_ok++;
          STAT_OVERFLOW: n_overflow++;
          default:       n_underflow++;
        endcase
      end
    end
  end

  // Underflow, value extremes and reuse of a queue whose tail went stale.
  task automatic test_empty_and_extremes();
    send_item(OP_DEQ, 2'd0, $urandom);
    send_item(OP_ENQ, 2'd0, 32'h7FFF_FFFF);
    send_item(OP_ENQ, 2'd0, 32'h8000_0000);
    send_item(OP_ENQ, 2'd3, 32'h0000_0000);
    send_item(OP_DEQ, 2'd0, $urandom);
    send_item(OP_DEQ, 2'd0, $urandom);
    send_item(OP_ENQ, 2'd0, 32'hFFFF_FFFF);
    send_item(OP_DEQ, 2'd3, $urandom);
    send_item(OP_DEQ, 2'd3, $urandom);
    send_item(OP_DEQ, 2'd0, $urandom);
  endtask

  // Fill every entry, then one more enqueue must overflow.
  task automatic test_full_store();
    for (int i = 0; i < NUM_ENTRIES; i++) send_item(OP_ENQ, 2'(i), $urandom);
    send_item(OP_ENQ, 2'd1, $urandom);
    wait_replies_drained();
  endtask

  // Enqueue bias drifts so occupancy swings between empty and full.
  task automatic test_random_traffic(int count);
    int  enq_bias;
    logic op;
    enq_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) enq_bias = $urandom_range(15, 85);
      op = ($urandom_range(99) < enq_bias) ? OP_ENQ : OP_DEQ;
      send_item(op, 2'($urandom_range(3)), $urandom);
    end
  endtask

  task automatic test_back_to_back(int count);
    steady_flow = 1'b1;
    test_random_traffic(count);
    wait_replies_drained();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    steady_flow = 1'b0;
    error_count = 0;
    clear_queue_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_and_extremes();
    test_full_store();
    test_random_traffic(250);
    test_back_to_back(90);
    test_random_traffic(180);

    wait_replies_drained();
    repeat (10) @(negedge clk);
    $display("Sent %0d enqueues and %0d dequeues over four queues sharing %0d entries",
             n_enq_sent, n_deq_sent, NUM_ENTRIES);
    $display("Results checked: %0d ok, %0d overflow, %0d underflow",
             n_ok, n_overflow, n_underflow);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sbmq_pkg.sv
rtl/core/sbmq_ram.sv
rtl/core/shared_buffer_multi_queue.sv
test/testbench.sv
